// ===== hdl/ofcc_pkg.sv =====
// ofcc_pkg: shared types, fixed-point constants and helpers for the flow color coder
// no dependencies; used by ofcc_value, ofcc_hue, optical_flow_color_coder_unit and the bench
package ofcc_pkg;

  localparam int FLOW_FRAC_BITS = 12;
  localparam int NORM_FRAC      = 24;

  // magnitude square root: input is x*x+y*y scaled up to Q48
  localparam int SQ_SHIFT = 2 * (NORM_FRAC - FLOW_FRAC_BITS);
  localparam int SQ_W     = 32 + SQ_SHIFT;
  localparam int SQ_H     = SQ_W / 2;

  localparam logic [24:0] SHIFT_Q24 = 25'd16760439;
  localparam logic [24:0] UPPER_Q24 = 25'd18438160;
  localparam int          LOG_STEPS = 20;
  localparam logic [17:0] LOG2_UPPER_Q20 = 18'd142807;
  localparam int          DIV_STEPS = 19;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam int CORDIC_STEPS = 16;
  localparam int CW           = 28;
  localparam int ZW           = 21;
  localparam int TURN_UNITS   = 393216;
  localparam int HALF_TURN    = 196608;
  localparam int CORDIC_ANGLE [CORDIC_STEPS] = '{
    49152, 29016, 15331, 7782, 3906, 1955, 978, 489,
    244, 122, 61, 31, 15, 8, 4, 2
  };

  // pipeline depths
  localparam int VAL_LAT  = 1 + SQ_H + 1 + LOG_STEPS + DIV_STEPS + 1;
  localparam int HUE_LAT  = 1 + CORDIC_STEPS + 1;
  localparam int HUE_DLY  = VAL_LAT - HUE_LAT;
  localparam int PIPE_LAT = VAL_LAT + 2;

  // hue sectors of 60 degrees
  localparam logic [2:0] SEC_RED_UP    = 3'd0;
  localparam logic [2:0] SEC_GREEN_UP  = 3'd1;
  localparam logic [2:0] SEC_GREEN_TOP = 3'd2;
  localparam logic [2:0] SEC_BLUE_UP   = 3'd3;
  localparam logic [2:0] SEC_BLUE_TOP  = 3'd4;

  typedef struct packed {
    logic signed [15:0] flow_x;
    logic signed [15:0] flow_y;
  } in_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } out_t;

  // arithmetic right shift that rounds toward zero
  function automatic logic signed [CW-1:0] shr_trunc(input logic signed [CW-1:0] v,
                                                     input int sh);
    logic signed [CW-1:0] m;
    m = v[CW-1] ? -v : v;
    m = m >>> sh;
    return v[CW-1] ? -m : m;
  endfunction

endpackage

// ===== hdl/ofcc_value.sv =====
// ofcc_value: pipelined brightness path, magnitude square root, log2 and scaling
// depends on ofcc_pkg
module ofcc_value (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  output logic [16:0]        v_q16
);
  import ofcc_pkg::*;

  logic signed [31:0] xx, yy;
  logic [31:0] s_r;

  assign xx = x * x;
  assign yy = y * y;

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= 32'(xx) + 32'(yy);
    end
  end

  // one root bit per stage
  logic [SQ_W-1:0] sq_q_r   [SQ_H];
  logic [SQ_W-1:0] sq_res_r [SQ_H];

  for (genvar k = 0; k < SQ_H; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_H - 1 - k));
    logic [SQ_W-1:0] q_i, res_i, q_n, res_n;
    logic [SQ_W:0]   trial;
    if (k == 0) begin : g_first
      assign q_i   = SQ_W'(s_r) << SQ_SHIFT;
      assign res_i = '0;
    end else begin : g_next
      assign q_i   = sq_q_r[k-1];
      assign res_i = sq_res_r[k-1];
    end
    always_comb begin
      trial = {1'b0, res_i} + {1'b0, BIT};
      if ({1'b0, q_i} >= trial) begin
        q_n   = q_i - trial[SQ_W-1:0];
        res_n = (res_i >> 1) + BIT;
      end else begin
        q_n   = q_i;
        res_n = res_i >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_q_r[k]   <= q_n;
        sq_res_r[k] <= res_n;
      end
    end
  end

  // offset and range check; flags [1] saturate, [0] black
  logic [SQ_H:0] w;
  logic [1:0]    wfl_r;
  logic [31:0]   wacc_r;

  assign w = {1'b0, sq_res_r[SQ_H-1][SQ_H-1:0]} + (SQ_H+1)'(SHIFT_Q24);

  always_ff @(posedge clk) begin
    if (en) begin
      wfl_r  <= {w >= (SQ_H+1)'(UPPER_Q24), w < (SQ_H+1)'(32'h0100_0000)};
      wacc_r <= {1'b0, w[24:0], 6'b0};
    end
  end

  // log2 by repeated squaring, one result bit per stage
  logic [31:0]          lacc_r [LOG_STEPS];
  logic [LOG_STEPS-1:0] llg_r  [LOG_STEPS];
  logic [1:0]           lfl_r  [LOG_STEPS];

  for (genvar k = 0; k < LOG_STEPS; k++) begin : g_log
    logic [31:0]          a;
    logic [LOG_STEPS-1:0] lg;
    logic [1:0]           fl;
    logic [63:0]          p;
    logic                 hi;
    if (k == 0) begin : g_first
      assign a  = wacc_r;
      assign lg = '0;
      assign fl = wfl_r;
    end else begin : g_next
      assign a  = lacc_r[k-1];
      assign lg = llg_r[k-1];
      assign fl = lfl_r[k-1];
    end
    assign p  = 64'(a) * 64'(a);
    assign hi = p[61];
    always_ff @(posedge clk) begin
      if (en) begin
        lacc_r[k] <= hi ? p[62:31] : p[61:30];
        llg_r[k]  <= {lg[LOG_STEPS-2:0], hi};
        lfl_r[k]  <= fl;
      end
    end
  end

  // (lg << 16) / log2(1.099), one quotient bit per stage
  logic [17:0]          drem_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] dq_r   [DIV_STEPS];
  logic [LOG_STEPS-1:0] dlg_r  [DIV_STEPS];
  logic [1:0]           dfl_r  [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int J = DIV_STEPS - 1 - k;
    logic [17:0]          rem;
    logic [DIV_STEPS-1:0] q;
    logic [LOG_STEPS-1:0] lg;
    logic [1:0]           fl;
    logic [18:0]          trial;
    logic                 nbit, ge;
    if (k == 0) begin : g_first
      assign rem = 18'(llg_r[LOG_STEPS-1] >> 3);
      assign q   = '0;
      assign lg  = llg_r[LOG_STEPS-1];
      assign fl  = lfl_r[LOG_STEPS-1];
    end else begin : g_next
      assign rem = drem_r[k-1];
      assign q   = dq_r[k-1];
      assign lg  = dlg_r[k-1];
      assign fl  = dfl_r[k-1];
    end
    if (J >= 16) begin : g_nb
      assign nbit = lg[J-16];
    end else begin : g_nz
      assign nbit = 1'b0;
    end
    assign trial = {rem, nbit};
    assign ge    = trial >= {1'b0, LOG2_UPPER_Q20};
    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[k] <= ge ? 18'(trial - {1'b0, LOG2_UPPER_Q20}) : trial[17:0];
        dq_r[k]   <= {q[DIV_STEPS-2:0], ge};
        dlg_r[k]  <= lg;
        dfl_r[k]  <= fl;
      end
    end
  end

  logic [DIV_STEPS-1:0] qv;
  logic [1:0]           qfl;
  logic [16:0]          v_r;

  assign qv  = dq_r[DIV_STEPS-1];
  assign qfl = dfl_r[DIV_STEPS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (qfl[1]) begin
        v_r <= ONE_Q16;
      end else if (qfl[0]) begin
        v_r <= '0;
      end else if (qv > DIV_STEPS'(ONE_Q16)) begin
        v_r <= ONE_Q16;
      end else begin
        v_r <= qv[16:0];
      end
    end
  end

  assign v_q16 = v_r;

endmodule

// ===== hdl/ofcc_hue.sv =====
// ofcc_hue: pipelined CORDIC vectoring of the reversed flow vector into hue units
// depends on ofcc_pkg
module ofcc_hue (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  output logic [18:0]        hue
);
  import ofcc_pkg::*;

  logic signed [CW-1:0] u0, v0;
  logic signed [CW-1:0] cu_r [CORDIC_STEPS+1];
  logic signed [CW-1:0] cv_r [CORDIC_STEPS+1];
  logic signed [ZW-1:0] cz_r [CORDIC_STEPS+1];

  assign u0 = -(CW'(x)) <<< 8;
  assign v0 = -(CW'(y)) <<< 8;

  // fold the left half plane onto the right one
  always_ff @(posedge clk) begin
    if (en) begin
      if (u0 < 0) begin
        cu_r[0] <= -u0;
        cv_r[0] <= -v0;
        cz_r[0] <= ZW'(HALF_TURN);
      end else begin
        cu_r[0] <= u0;
        cv_r[0] <= v0;
        cz_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CW-1:0] su, sv;
    assign su = shr_trunc(cu_r[i], i);
    assign sv = shr_trunc(cv_r[i], i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (cv_r[i] >= 0) begin
          cu_r[i+1] <= cu_r[i] + sv;
          cv_r[i+1] <= cv_r[i] - su;
          cz_r[i+1] <= cz_r[i] + ZW'(CORDIC_ANGLE[i]);
        end else begin
          cu_r[i+1] <= cu_r[i] - sv;
          cv_r[i+1] <= cv_r[i] + su;
          cz_r[i+1] <= cz_r[i] - ZW'(CORDIC_ANGLE[i]);
        end
      end
    end
  end

  logic signed [ZW-1:0] zf;
  logic [18:0]          h_r;

  assign zf = cz_r[CORDIC_STEPS];

  // angle never reaches a full turn, only negatives need wrapping
  always_ff @(posedge clk) begin
    if (en) begin
      h_r <= zf[ZW-1] ? 19'(zf + ZW'(TURN_UNITS)) : 19'(zf);
    end
  end

  assign hue = h_r;

endmodule

// ===== hdl/optical_flow_color_coder_unit.sv =====
// optical_flow_color_coder_unit: top level, flow vector in, RGB pixel out
// depends on ofcc_pkg, ofcc_value and ofcc_hue
//
// One flow vector per clock goes in and one RGB pixel per clock comes out, in
// order, as long as out_ready stays high and the skid entry is empty. The depth
// is set by the brightness path: a square root with one root bit per stage,
// twenty squaring stages for log2 and a bit-per-stage scaling divide; the hue
// CORDIC runs alongside and is delayed to match. The whole pipeline advances
// together and an output register with one skid entry lets two results wait
// on out_ready before in_ready drops.
module optical_flow_color_coder_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ofcc_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ofcc_pkg::out_t out_data
);
  import ofcc_pkg::*;

  logic en;
  logic vld_r [PIPE_LAT];
  logic [16:0] v_q16;
  logic [18:0] hue;
  logic [18:0] hd_r [HUE_DLY];

  logic out_vld_r, skid_vld_r;
  out_t out_r, skid_r;

  assign en       = !skid_vld_r;
  assign in_ready = en;

  ofcc_value u_value (
    .clk   (clk),
    .en    (en),
    .x     (in_data.flow_x),
    .y     (in_data.flow_y),
    .v_q16 (v_q16)
  );

  ofcc_hue u_hue (
    .clk (clk),
    .en  (en),
    .x   (in_data.flow_x),
    .y   (in_data.flow_y),
    .hue (hue)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < PIPE_LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hd_r[0] <= hue;
      for (int i = 1; i < HUE_DLY; i++) hd_r[i] <= hd_r[i-1];
    end
  end

  // color stage 1: top level and value times fraction
  logic [18:0] h;
  logic [2:0]  sec;
  logic [16:0] f;
  logic [24:0] top_full;
  logic [7:0]  c1_top_r;
  logic [33:0] c1_vf_r;
  logic [2:0]  c1_sec_r;

  assign h        = hd_r[HUE_DLY-1];
  assign sec      = h[18:16];
  assign f        = sec[0] ? (ONE_Q16 - {1'b0, h[15:0]}) : {1'b0, h[15:0]};
  assign top_full = 25'(v_q16) * 25'd255;

  always_ff @(posedge clk) begin
    if (en) begin
      c1_top_r <= top_full[23:16];
      c1_vf_r  <= 34'(v_q16) * 34'(f);
      c1_sec_r <= sec;
    end
  end

  // color stage 2: ramp level and sector mux
  logic [41:0] mid_full;
  logic [7:0]  mid;
  out_t        px, c2_r;

  assign mid_full = 42'(c1_vf_r) * 42'd255;
  assign mid      = mid_full[39:32];

  always_comb begin
    px = '0;
    case (c1_sec_r)
      SEC_RED_UP: begin
        px.red   = c1_top_r;
        px.green = mid;
      end
      SEC_GREEN_UP: begin
        px.red   = mid;
        px.green = c1_top_r;
      end
      SEC_GREEN_TOP: begin
        px.green = c1_top_r;
        px.blue  = mid;
      end
      SEC_BLUE_UP: begin
        px.green = mid;
        px.blue  = c1_top_r;
      end
      SEC_BLUE_TOP: begin
        px.red  = mid;
        px.blue = c1_top_r;
      end
      default: begin
        px.red  = c1_top_r;
        px.blue = mid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_r <= px;
    end
  end

  // output register plus one skid entry
  logic push, pop;
  assign push = en && vld_r[PIPE_LAT-1];
  assign pop  = out_vld_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        out_r      <= skid_r;
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_vld_r || pop) begin
        out_r     <= c2_r;
        out_vld_r <= 1'b1;
      end else begin
        skid_r     <= c2_r;
        skid_vld_r <= 1'b1;
      end
    end else if (pop) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held without an output transaction pending");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && !out_ready))
    else $error("skid entry filled while the output was free");

  a_result_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_vld_r)
    else $error("pipeline result lost at the output register");

endmodule

// ===== bench/tb_optical_flow_color_coder_unit.sv =====
`timescale 1ns / 100ps
// tb_optical_flow_color_coder_unit: self-checking bench for the flow color coder
// depends on ofcc_pkg and optical_flow_color_coder_unit; fixed-point predictor inside
module tb_optical_flow_color_coder_unit;
  import ofcc_pkg::*;

  localparam int N_RANDOM = 1600;
  localparam int N_DIR = 14;
  localparam int LAT = 84 - FLOW_FRAC_BITS;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  optical_flow_color_coder_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  out_t pixel_q[$];
  int err_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // directed rows: flow_x, flow_y, typed pixel where obvious, known flag
  typedef struct {
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    out_t px;
    bit known;
  } dir_row_t;

  dir_row_t dir_rows [N_DIR] = '{
    '{16'sd0, 16'sd0, 24'h000000, 1'b1},          // zero vector: black
    '{16'sd4, 16'sd0, 24'h000000, 1'b1},          // tiny magnitude: black
    '{16'sd0, -16'sd4, 24'h000000, 1'b1},
    '{-16'sd4096, 16'sd0, 24'h0000ff, 1'b1},      // hue 0: pure red, full value
    '{16'sd4096, 16'sd0, 24'h000000, 1'b0},
    '{16'sd0, 16'sd4096, 24'h000000, 1'b0},
    '{16'sd0, -16'sd4096, 24'h000000, 1'b0},
    '{-16'sd32768, -16'sd32768, 24'h000000, 1'b0}, // most negative inputs
    '{16'sd32767, 16'sd32767, 24'h000000, 1'b0},
    '{-16'sd32768, 16'sd32767, 24'h000000, 1'b0},
    '{16'sd32767, -16'sd32768, 24'h000000, 1'b0},
    '{16'sd200, 16'sd150, 24'h000000, 1'b0},       // value ramp region
    '{-16'sd100, 16'sd300, 24'h000000, 1'b0},
    '{16'sd410, -16'sd5, 24'h000000, 1'b0}
  };

  function automatic longint unsigned int_sqrt(input longint unsigned q);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > q) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (q >= res + bitv) begin
        q = q - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint toward_zero(input longint v, input int sh);
    return (v >= 0) ? (v >>> sh) : -((-v) >>> sh);
  endfunction

  function automatic longint unsigned brightness_q16(input longint x, input longint y);
    longint unsigned s, r, w, acc, lg, v;
    s = longint'(x * x) + longint'(y * y);
    r = int_sqrt(s << (2 * (NORM_FRAC - FLOW_FRAC_BITS)));
    w = r + 64'd16760439;
    lg = 0;
    if (w < (64'd1 << NORM_FRAC)) return 0;
    if (w >= 64'd18438160) return 65536;
    acc = w << 6;
    for (int k = 0; k < 20; k++) begin
      acc = (acc * acc) >> 30;
      lg = lg << 1;
      if (acc >= (64'd1 << 31)) begin
        lg = lg | 1;
        acc = acc >> 1;
      end
    end
    v = (lg << 16) / 64'd142807;
    return (v > 65536) ? 65536 : v;
  endfunction

  function automatic longint hue_angle(input longint x, input longint y);
    longint u, v, z, nu, nv;
    u = -x * 256;
    v = -y * 256;
    z = 0;
    if (u < 0) begin
      u = -u;
      v = -v;
      z = HALF_TURN;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (v >= 0) begin
        nu = u + toward_zero(v, i);
        nv = v - toward_zero(u, i);
        z = z + CORDIC_ANGLE[i];
      end else begin
        nu = u - toward_zero(v, i);
        nv = v + toward_zero(u, i);
        z = z - CORDIC_ANGLE[i];
      end
      u = nu;
      v = nv;
    end
    z = z % TURN_UNITS;
    if (z < 0) z = z + TURN_UNITS;
    return z;
  endfunction

  function automatic out_t color_pixel(input logic signed [15:0] fx,
                                       input logic signed [15:0] fy);
    longint unsigned val, t, f, top, mid;
    longint h;
    int sector;
    out_t px;
    val = brightness_q16(longint'(fx), longint'(fy));
    h = hue_angle(longint'(fx), longint'(fy));
    sector = int'(h >> 16);
    t = h & 64'hffff;
    f = (sector % 2 == 1) ? (65536 - t) : t;
    top = (val * 255) >> 16;
    mid = (val * f * 255) >> 32;
    px = '0;
    case (sector)
      SEC_RED_UP: begin px.red = 8'(top); px.green = 8'(mid); end
      SEC_GREEN_UP: begin px.red = 8'(mid); px.green = 8'(top); end
      SEC_GREEN_TOP: begin px.green = 8'(top); px.blue = 8'(mid); end
      SEC_BLUE_UP: begin px.green = 8'(mid); px.blue = 8'(top); end
      SEC_BLUE_TOP: begin px.red = 8'(mid); px.blue = 8'(top); end
      default: begin px.red = 8'(top); px.blue = 8'(mid); end
    endcase
    return px;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    err_count++;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // drive one transaction, with random sender gaps before it
  task automatic send_pixel(input logic signed [15:0] fx, input logic signed [15:0] fy,
                            input out_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{flow_x: fx, flow_y: fy};
    pixel_q.push_back(px);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_flow();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return $signed(16'($urandom_range(1000))) - 16'sd500;
      2: return $signed(16'($urandom_range(12))) - 16'sd6;
      default: return $urandom_range(1) ? 16'sh7fff - 16'($urandom_range(3))
                                        : 16'sh8000 + 16'($urandom_range(3));
    endcase
  endfunction

  // receiver: random stall, checks each output transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          report_mismatch("pixel with none expected");
        end else begin
          out_t e;
          e = pixel_q.pop_front();
          if (out_data.red !== e.red)
            report_mismatch($sformatf("red %0d exp %0d", out_data.red, e.red));
          if (out_data.green !== e.green)
            report_mismatch($sformatf("green %0d exp %0d", out_data.green, e.green));
          if (out_data.blue !== e.blue)
            report_mismatch($sformatf("blue %0d exp %0d", out_data.blue, e.blue));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int wait_cnt;
    logic signed [15:0] fx, fy;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < N_DIR; i++) begin
      send_pixel(dir_rows[i].fx, dir_rows[i].fy,
                 dir_rows[i].known ? dir_rows[i].px
                                   : color_pixel(dir_rows[i].fx, dir_rows[i].fy));
    end
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 63; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 63; end
        3: begin send_idle_pct = 37; recv_stall_pct = 37; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < N_RANDOM / 5; n++) begin
        fx = rand_flow();
        fy = rand_flow();
        send_pixel(fx, fy, color_pixel(fx, fy));
      end
    end
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    wait_cnt = 0;
    while (pixel_q.size() != 0 && wait_cnt < 100_000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (LAT + 10) @(posedge clk);
    if (pixel_q.size() != 0) report_mismatch("pixels left unseen");
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ofcc_pkg.sv
hdl/ofcc_value.sv
hdl/ofcc_hue.sv
hdl/optical_flow_color_coder_unit.sv
bench/tb_optical_flow_color_coder_unit.sv
